FILE: sv/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared types, constants and a helper function of the pose residual core.
// ----------------------------------------------------------------------------
package rpr_pkg;

  localparam int FracBits = 16;
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] REG_ROT_X   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROT_Y   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROT_Z   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SHIFT_Z = 3'd5;

  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  typedef logic signed [31:0] word_t;
  typedef word_t [8:0] matrix_t;

  typedef struct packed {
    word_t ref_x;
    word_t ref_y;
    word_t ref_z;
    word_t src_x;
    word_t src_y;
    word_t src_z;
    logic  last_sensor;
  } item_t;

  typedef struct packed {
    word_t err_x;
    word_t err_y;
    word_t err_z;
    logic  last_out;
  } result_t;

  typedef struct packed {
    matrix_t   rot;
    word_t [2:0] shift;
  } pose_t;

  // Shift right by 30 with rounding half away from zero.
  function automatic logic signed [34:0] shr_round30(input logic signed [63:0] v);
    logic [63:0] m;
    logic [33:0] r;
    m = v[63] ? (~v + 64'd1) : v;
    r = 34'((m + 64'h2000_0000) >> 30);
    return v[63] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

endpackage

FILE: sv/rigid_pose_residual_core.sv
// ----------------------------------------------------------------------------
// rigid_pose_residual_core
// Rotates and translates a frame-B point by the programmed pose and returns
// its saturated difference from the frame-A point.
// ----------------------------------------------------------------------------
// Sensor pairs stream at one transfer per clock cycle while item_stall is low;
// each accepted item passes through a two-entry queue and a three-stage
// multiply, round and saturate datapath. A write to one of the six pose
// registers starts the rotation matrix derivation, which runs a shared
// multiplier and a one-bit-per-cycle divider; most of its work is the
// 31-step division of each of the four quaternion components, and item_stall
// stays high and cfg_ready low throughout.
module rigid_pose_residual_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rpr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  rpr_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output rpr_pkg::result_t            result
);
  import rpr_pkg::*;

  pose_t pose;
  logic  q_full;
  logic  q_push;
  logic  q_nonempty;
  logic  q_pop;
  item_t q_data;

  rpr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .q_full     (q_full),
    .q_push     (q_push),
    .pose       (pose)
  );

  rpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (item),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  rpr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_nonempty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .pose         (pose),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: sv/rpr_front.sv
// ----------------------------------------------------------------------------
// rpr_front
// Pose registers, rotation matrix derivation and input acceptance.
// ----------------------------------------------------------------------------
module rpr_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [rpr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic                    q_full,
  output logic                    q_push,
  output rpr_pkg::pose_t          pose
);
  import rpr_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQ   = 7'b0000010,
    ST_PREP = 7'b0000100,
    ST_NORM = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_MUL  = 7'b0100000,
    ST_MAT  = 7'b1000000
  } state_t;

  localparam logic [63:0] QuatOne = 64'd1 << (2 * FracBits);

  state_t      state;
  word_t [5:0] regs;
  matrix_t     rot;
  logic [3:0]  cnt;
  logic [63:0] acc_a;
  logic [63:0] preg;
  logic [63:0] dsh;
  logic [63:0] nw, nx, ny, nz;
  logic        neg_w;
  logic [1:0]  comp;
  logic [4:0]  bitc;
  logic [31:0] rem;
  logic [30:0] quo;
  word_t [3:0] qv;
  logic signed [63:0] prods [9];

  logic [31:0] mag_sel, mag_x, mag_y, mag_z;
  logic [63:0] n_sel;
  logic [31:0] dn;
  logic [32:0] trial;
  logic        qbit;
  logic [30:0] q_fin;
  logic        neg_sel;
  word_t       mul_a, mul_b;
  matrix_t     mat_next;
  logic        cfg_fire;

  function automatic logic [31:0] mag32(input word_t v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic word_t clamp_q30(input logic signed [35:0] v);
    if (v > 36'(Q30_ONE)) begin
      return Q30_ONE;
    end else if (v < -36'(Q30_ONE)) begin
      return -Q30_ONE;
    end
    return v[31:0];
  endfunction

  function automatic word_t off_diag(input logic signed [63:0] pa,
                                     input logic signed [63:0] pb, input logic sub);
    logic signed [63:0] s;
    s = sub ? (pa - pb) : (pa + pb);
    return clamp_q30(36'(shr_round30(s <<< 1)));
  endfunction

  function automatic word_t on_diag(input logic signed [63:0] pa,
                                    input logic signed [63:0] pb);
    logic signed [63:0] s;
    s = (pa + pb) <<< 1;
    return clamp_q30(36'(Q30_ONE) - 36'(shr_round30(s)));
  endfunction

  assign cfg_ready  = (state == ST_IDLE);
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign item_stall = (state != ST_IDLE) || q_full;
  assign q_push     = item_valid && !item_stall;

  assign pose.rot   = rot;
  assign pose.shift = regs[5:3];

  assign mag_x = mag32(regs[REG_ROT_X]);
  assign mag_y = mag32(regs[REG_ROT_Y]);
  assign mag_z = mag32(regs[REG_ROT_Z]);

  always_comb begin
    case (cnt[1:0])
      2'd0:    mag_sel = mag_x;
      2'd1:    mag_sel = mag_y;
      default: mag_sel = mag_z;
    endcase
  end

  always_comb begin
    case (comp)
      2'd0: begin
        n_sel = nw; neg_sel = neg_w;
      end
      2'd1: begin
        n_sel = nx; neg_sel = regs[REG_ROT_X][31];
      end
      2'd2: begin
        n_sel = ny; neg_sel = regs[REG_ROT_Y][31];
      end
      default: begin
        n_sel = nz; neg_sel = regs[REG_ROT_Z][31];
      end
    endcase
  end

  assign dn    = dsh[31:0];
  assign trial = (bitc == 5'd0) ? {1'b0, n_sel[31:0]} : {rem, 1'b0};
  assign qbit  = (trial >= {1'b0, dn});
  assign q_fin = {quo[29:0], qbit};

  // Product order: yy, zz, xy, wz, xz, wy, xx, yz, wx.
  always_comb begin
    case (cnt)
      4'd0:    begin mul_a = qv[2]; mul_b = qv[2]; end
      4'd1:    begin mul_a = qv[3]; mul_b = qv[3]; end
      4'd2:    begin mul_a = qv[1]; mul_b = qv[2]; end
      4'd3:    begin mul_a = qv[0]; mul_b = qv[3]; end
      4'd4:    begin mul_a = qv[1]; mul_b = qv[3]; end
      4'd5:    begin mul_a = qv[0]; mul_b = qv[2]; end
      4'd6:    begin mul_a = qv[1]; mul_b = qv[1]; end
      4'd7:    begin mul_a = qv[2]; mul_b = qv[3]; end
      default: begin mul_a = qv[0]; mul_b = qv[1]; end
    endcase
  end

  always_comb begin
    mat_next[0] = on_diag(prods[0], prods[1]);
    mat_next[1] = off_diag(prods[2], prods[3], 1'b1);
    mat_next[2] = off_diag(prods[4], prods[5], 1'b0);
    mat_next[3] = off_diag(prods[2], prods[3], 1'b0);
    mat_next[4] = on_diag(prods[6], prods[1]);
    mat_next[5] = off_diag(prods[7], prods[8], 1'b1);
    mat_next[6] = off_diag(prods[4], prods[5], 1'b1);
    mat_next[7] = off_diag(prods[7], prods[8], 1'b0);
    mat_next[8] = on_diag(prods[6], prods[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      regs  <= '0;
      rot   <= '{Q30_ONE, '0, '0, '0, Q30_ONE, '0, '0, '0, Q30_ONE};
      cnt   <= '0;
      comp  <= '0;
      bitc  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cfg_fire && (cfg_index <= REG_SHIFT_Z)) begin
            regs[cfg_index] <= cfg_data;
            cnt   <= '0;
            acc_a <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (cnt != 4'd3) begin
            preg <= 64'(mag_sel) * 64'(mag_sel);
          end
          if (cnt != 4'd0) begin
            acc_a <= acc_a + preg;
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd3) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          dsh   <= QuatOne + acc_a;
          neg_w <= (acc_a > QuatOne);
          nw    <= (acc_a > QuatOne) ? (acc_a - QuatOne) : (QuatOne - acc_a);
          nx    <= 64'(mag_x) << (FracBits + 1);
          ny    <= 64'(mag_y) << (FracBits + 1);
          nz    <= 64'(mag_z) << (FracBits + 1);
          state <= ST_NORM;
        end
        ST_NORM: begin
          if (dsh[63:32] != 32'd0) begin
            dsh <= dsh >> 1;
            nw  <= nw >> 1;
            nx  <= nx >> 1;
            ny  <= ny >> 1;
            nz  <= nz >> 1;
          end else begin
            comp  <= '0;
            bitc  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= qbit ? 32'(trial - {1'b0, dn}) : trial[31:0];
          quo <= q_fin;
          if (bitc == 5'd30) begin
            qv[comp] <= neg_sel ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
            bitc <= '0;
            comp <= comp + 2'd1;
            if (comp == 2'd3) begin
              cnt   <= '0;
              state <= ST_MUL;
            end
          end else begin
            bitc <= bitc + 5'd1;
          end
        end
        ST_MUL: begin
          prods[cnt] <= mul_a * mul_b;
          cnt <= cnt + 4'd1;
          if (cnt == 4'd8) begin
            state <= ST_MAT;
          end
        end
        ST_MAT: begin
          rot   <= mat_next;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/rpr_queue.sv
// ----------------------------------------------------------------------------
// rpr_queue
// Two-entry queue that decouples the front from the residual datapath.
// ----------------------------------------------------------------------------
module rpr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rpr_pkg::item_t push_data,
  output logic           full,
  output logic           nonempty,
  input  logic           pop,
  output rpr_pkg::item_t pop_data
);
  import rpr_pkg::*;

  item_t      entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign pop_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/rpr_back.sv
// ----------------------------------------------------------------------------
// rpr_back
// Three-stage residual datapath: products, rounded row sums, offset and
// saturation into the output register.
// ----------------------------------------------------------------------------
module rpr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  rpr_pkg::item_t   q_data,
  output logic             q_pop,
  input  rpr_pkg::pose_t   pose,
  output logic             result_valid,
  input  logic             result_stall,
  output rpr_pkg::result_t result
);
  import rpr_pkg::*;

  logic               v1, v2, v3;
  logic               adv;
  logic signed [63:0] p1 [9];
  word_t [2:0]        ref1, ref2;
  logic               last1, last2;
  logic signed [34:0] rnd2 [3];
  word_t [2:0]        src_vec;
  word_t [2:0]        ref_vec;
  word_t [2:0]        err_next;
  result_t            res;

  assign adv   = !v3 || !result_stall;
  assign q_pop = adv && q_valid;

  assign src_vec = {q_data.src_z, q_data.src_y, q_data.src_x};
  assign ref_vec = {q_data.ref_z, q_data.ref_y, q_data.ref_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [35:0] e;
      e = 36'(rnd2[i]) + 36'(pose.shift[i]) - 36'(ref2[i]);
      if (e > 36'sh0_7FFF_FFFF) begin
        err_next[i] = 32'sh7FFF_FFFF;
      end else if (e < -36'sh0_8000_0000) begin
        err_next[i] = 32'sh8000_0000;
      end else begin
        err_next[i] = e[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        p1[k] <= pose.rot[k] * src_vec[k % 3];
      end
      ref1  <= ref_vec;
      last1 <= q_data.last_sensor;
      for (int i = 0; i < 3; i++) begin
        rnd2[i] <= shr_round30(p1[3*i] + p1[3*i+1] + p1[3*i+2]);
      end
      ref2  <= ref1;
      last2 <= last1;
      res.err_x    <= err_next[0];
      res.err_y    <= err_next[1];
      res.err_z    <= err_next[2];
      res.last_out <= last2;
    end
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign result_valid = v3;
  assign result       = res;

endmodule
